[hdl/assert_macros.svh]
// Assertion macros shared by the SM3 hash core.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hdl/sm3_pkg.sv]
// Package for the SM3 hash core: constants, word types and round functions.
// No dependencies.
package sm3_pkg;
    localparam logic [31:0] TJ_LOW  = 32'h79cc4519;
    localparam logic [31:0] TJ_HIGH = 32'h7a879d8a;
    localparam logic [7:0]  PAD     = 8'h80;
    localparam logic [255:0] IV = {32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
                                   32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  byte_count;
        logic        final_word;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        last_word;
    } t_out_word;

    typedef struct packed {
        logic [31:0] word;
        logic        fin;
        logic [2:0]  nbytes;
    } t_cmd;

    function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
    endfunction
endpackage

[hdl/sm3_if.sv]
// Valid/ready channel interface carrying one word of payload.
// Depends on nothing; payload type is a parameter.
interface sm3_if #(parameter type T = logic [31:0]);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/sm3_front.sv]
// Front end: accepts input words, clamps byte counts, two-entry queue.
// Depends on sm3_pkg.
module sm3_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_word,
    input  logic [2:0]         i_nbytes,
    input  logic               i_fin,
    output logic               o_valid,
    input  logic               i_ready,
    output sm3_pkg::t_cmd      o_cmd
);
    sm3_pkg::t_cmd r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;
    sm3_pkg::t_cmd w_in;
    logic push, pop;

    always_comb begin
        w_in.word   = i_word;
        w_in.fin    = i_fin;
        w_in.nbytes = (!i_fin || i_nbytes > 3'd4) ? 3'd4 : i_nbytes;
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_q[r_wr] <= w_in;
        end
    end
endmodule

[hdl/sm3_back.sv]
// Back end: block buffer, padding, expansion window and one round per cycle.
// Depends on sm3_pkg.
module sm3_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sm3_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_digest,
    output logic          o_last
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FILL = 5'b00010,
        S_RND  = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_st;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_cv [8];
    logic [3:0]  r_fill;
    logic [63:0] r_len;
    logic [5:0]  r_j;
    logic        r_fin, r_last_blk;
    logic [2:0]  r_k;
    logic [31:0] r_tr;
    // A padding block runs without length only when the pad word landed past word 13.
    logic        r_xtra;

    logic [31:0] w_pad, a12, ss1, ss2, ff, gg, tt1, tt2, wn;
    logic [31:0] n_v [8];
    logic [2:0]  nb;

    assign o_ready  = (r_st == S_IDLE);
    assign o_valid  = (r_st == S_OUT);
    assign o_digest = r_cv[r_k];
    assign o_last   = (r_k == 3'd7);
    assign nb       = i_cmd.nbytes;

    always_comb begin
        w_pad = ((nb == 3'd0) ? 32'd0 : (i_cmd.word & (32'hffffffff << (6'd32 - {nb, 3'b000}))))
              | ({24'd0, sm3_pkg::PAD} << (5'd24 - {nb[1:0], 3'b000}));
        a12 = sm3_pkg::rol(r_v[0], 5'd12);
        ss1 = sm3_pkg::rol(a12 + r_v[4] + r_tr, 5'd7);
        ss2 = ss1 ^ a12;
        if (r_j < 6'd16) begin
            ff = r_v[0] ^ r_v[1] ^ r_v[2];
            gg = r_v[4] ^ r_v[5] ^ r_v[6];
        end else begin
            ff = (r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]);
            gg = (r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]);
        end
        tt1 = ff + r_v[3] + ss2 + (r_w[0] ^ r_w[4]);
        tt2 = gg + r_v[7] + ss1 + r_w[0];
        wn  = sm3_pkg::p1(r_w[0] ^ r_w[7] ^ sm3_pkg::rol(r_w[13], 5'd15))
            ^ sm3_pkg::rol(r_w[3], 5'd7) ^ r_w[10];
        n_v[0] = tt1;
        n_v[1] = r_v[0];
        n_v[2] = sm3_pkg::rol(r_v[1], 5'd9);
        n_v[3] = r_v[2];
        n_v[4] = sm3_pkg::p0(tt2);
        n_v[5] = r_v[4];
        n_v[6] = sm3_pkg::rol(r_v[5], 5'd19);
        n_v[7] = r_v[6];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_fill <= 4'd0;
            r_len  <= 64'd0;
            r_k    <= 3'd0;
            for (int i = 0; i < 8; i++) begin
                r_cv[i] <= sm3_pkg::IV[255 - 32*i -: 32];
            end
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_fin <= i_cmd.fin;
                        if (nb == 3'd4) begin
                            r_w[r_fill] <= i_cmd.word;
                            r_len <= r_len + 64'd32;
                            r_fill <= r_fill + 4'd1;
                            if (r_fill == 4'd15) begin
                                r_st <= S_RND;
                                r_last_blk <= 1'b0;
                            end else if (i_cmd.fin) begin
                                r_st <= S_FIN;
                            end
                        end else begin
                            r_w[r_fill] <= w_pad;
                            r_len <= r_len + {58'd0, nb, 3'b000};
                            r_fill <= r_fill + 4'd1;
                            if (r_fill == 4'd15) begin
                                r_st <= S_RND;
                                r_last_blk <= 1'b0;
                            end else begin
                                r_st <= S_FILL;
                            end
                        end
                        for (int i = 0; i < 8; i++) begin
                            r_v[i] <= r_cv[i];
                        end
                        r_j  <= 6'd0;
                        r_tr <= sm3_pkg::TJ_LOW;
                    end
                end
                S_FIN: begin
                    r_w[r_fill] <= {sm3_pkg::PAD, 24'd0};
                    r_fill <= r_fill + 4'd1;
                    if (r_fill == 4'd15) begin
                        r_st <= S_RND;
                        r_last_blk <= 1'b0;
                    end else begin
                        r_st <= S_FILL;
                    end
                    for (int i = 0; i < 8; i++) begin
                        r_v[i] <= r_cv[i];
                    end
                    r_j  <= 6'd0;
                    r_tr <= sm3_pkg::TJ_LOW;
                end
                S_FILL: begin
                    r_fill <= r_fill + 4'd1;
                    if (r_fill == 4'd14 && !r_xtra) begin
                        r_w[14] <= r_len[63:32];
                    end else if (r_fill == 4'd15 && !r_xtra) begin
                        r_w[15] <= r_len[31:0];
                    end else begin
                        r_w[r_fill] <= 32'd0;
                    end
                    if (r_fill == 4'd15) begin
                        r_st <= S_RND;
                        r_last_blk <= !r_xtra;
                    end
                    for (int i = 0; i < 8; i++) begin
                        r_v[i] <= r_cv[i];
                    end
                    r_j  <= 6'd0;
                    r_tr <= sm3_pkg::TJ_LOW;
                end
                S_RND: begin
                    for (int i = 0; i < 8; i++) begin
                        r_v[i] <= n_v[i];
                    end
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[15] <= wn;
                    r_j <= r_j + 6'd1;
                    r_tr <= (r_j == 6'd15) ? sm3_pkg::rol(sm3_pkg::TJ_HIGH, 5'd16)
                                           : sm3_pkg::rol(r_tr, 5'd1);
                    if (r_j == 6'd63) begin
                        r_fill <= 4'd0;
                        for (int i = 0; i < 8; i++) begin
                            r_cv[i] <= r_cv[i] ^ n_v[i];
                        end
                        if (r_last_blk) begin
                            r_st <= S_OUT;
                        end else if (r_fin && r_xtra) begin
                            r_st <= S_FILL;
                        end else if (r_fin) begin
                            r_st <= S_FIN;
                        end else begin
                            r_st <= S_IDLE;
                        end
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_k <= r_k + 3'd1;
                        if (r_k == 3'd7) begin
                            r_st  <= S_IDLE;
                            r_len <= 64'd0;
                            for (int i = 0; i < 8; i++) begin
                                r_cv[i] <= sm3_pkg::IV[255 - 32*i -: 32];
                            end
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xtra <= 1'b0;
        end else if (r_st == S_RND && r_j == 6'd63) begin
            r_xtra <= 1'b0;
        end else if ((r_st == S_IDLE && i_valid && i_cmd.fin && nb != 3'd4 && r_fill >= 4'd14)
                  || (r_st == S_FIN && r_fill >= 4'd14)) begin
            r_xtra <= 1'b1;
        end
    end
endmodule

[hdl/sm3_hash_core.sv]
// SM3 hash core top level: front queue and round engine.
// Depends on sm3_pkg, sm3_if, sm3_front, sm3_back and assert_macros.svh.
//
//  channel   dir  payload
//  i_in      in   message_word, byte_count, final_word
//  o_out     out  digest_word, last_word
//
// A non-final word is stored in the block buffer; a word that completes a block
// starts the 64 rounds of compression. A final word adds padding fill, 64 rounds
// (twice when an extra block is needed) and eight output words, which wait while
// o_out.ready is low.
// Reset is synchronous; the chaining value returns to the initial value.
// The two-entry queue keeps accepting words while the rounds run, until both entries are full.
`include "assert_macros.svh"
module sm3_hash_core (
    input  logic i_clk,
    input  logic i_rst_n,
    sm3_if.sink   i_in,
    sm3_if.source o_out
);
    logic          q_valid, q_ready;
    sm3_pkg::t_cmd q_cmd;
    logic [31:0]   dig;
    logic          lst;

    sm3_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_word(i_in.data.message_word), .i_nbytes(i_in.data.byte_count),
        .i_fin(i_in.data.final_word),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    sm3_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(o_out.valid), .i_ready(o_out.ready),
        .o_digest(dig), .o_last(lst)
    );

    assign o_out.data.digest_word = dig;
    assign o_out.data.last_word   = lst;

    `ASSERT_IMPL(a_no_take_busy, i_clk, i_rst_n, o_out.valid, !q_ready)
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready && !lst,
                 o_out.valid)
endmodule

[bench/testbench.sv]
// Self-checking testbench for the SM3 hash core: directed and random messages.
// Depends on sm3_pkg, sm3_if and sm3_hash_core from the design sources.
`timescale 1ns / 1ps
module testbench;
    typedef struct {
        logic [31:0]  word;
        logic [2:0]   nbytes;
        logic         fin;
        logic         known;
        logic [255:0] digest;
    } t_row;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int N_RANDOM       = 150;

    logic i_clk;
    logic i_rst_n;
    sm3_if #(.T(sm3_pkg::t_in_word))  in_ch ();
    sm3_if #(.T(sm3_pkg::t_out_word)) out_ch ();

    sm3_hash_core u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    logic [31:0]        chain[8];
    logic [31:0]        blk[16];
    int                 fill;
    logic [63:0]        bit_len;
    sm3_pkg::t_out_word digest_q[$];
    int                 errors = 0;
    int                 idle_cycles = 0;
    int                 gap_pct = 0;
    int                 stall_pct = 0;
    int                 digests = 0;
    int                 words_sent = 0;
    t_row               rows[$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotl(logic [31:0] x, int n);
        n = n % 32;
        return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
    endfunction

    task automatic compress();
        logic [31:0] w[68];
        logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
        for (int j = 0; j < 16; j++) w[j] = blk[j];
        for (int j = 16; j < 68; j++) begin
            tt1 = w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15);
            w[j] = tt1 ^ rotl(tt1, 15) ^ rotl(tt1, 23) ^ rotl(w[j-13], 7) ^ w[j-6];
        end
        {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                    chain[4], chain[5], chain[6], chain[7]};
        for (int j = 0; j < 64; j++) begin
            tj  = (j < 16) ? sm3_pkg::TJ_LOW : sm3_pkg::TJ_HIGH;
            a12 = rotl(a, 12);
            ss1 = rotl(a12 + e + rotl(tj, j % 32), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ff = a ^ b ^ c;
                gg = e ^ f ^ g;
            end else begin
                ff = (a & b) | (a & c) | (b & c);
                gg = (e & f) | (~e & g);
            end
            tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + h + ss1 + w[j];
            d = c; c = rotl(b, 9); b = a; a = tt1;
            h = g; g = rotl(f, 19); f = e;
            e = tt2 ^ rotl(tt2, 9) ^ rotl(tt2, 17);
        end
        chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
        chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
    endtask

    task automatic store_word(logic [31:0] w);
        blk[fill] = w;
        fill++;
        if (fill == 16) begin
            compress();
            fill = 0;
        end
    endtask

    task automatic restart_hash();
        for (int k = 0; k < 8; k++) chain[k] = sm3_pkg::IV[255 - 32*k -: 32];
        fill    = 0;
        bit_len = '0;
    endtask

    task automatic predict_digest(sm3_pkg::t_in_word cmd);
        int          nb;
        logic [31:0] pad_word;
        logic [31:0] mask;
        nb = (cmd.byte_count > 4) ? 4 : cmd.byte_count;
        if (!cmd.final_word) begin
            bit_len += 32;
            store_word(cmd.message_word);
            return;
        end
        if (nb == 4) begin
            bit_len += 32;
            store_word(cmd.message_word);
            pad_word = {sm3_pkg::PAD, 24'h0};
        end else begin
            mask = (nb == 0) ? 32'h0 : (32'hffffffff << (32 - 8*nb));
            pad_word = (cmd.message_word & mask) | (32'(sm3_pkg::PAD) << (24 - 8*nb));
            bit_len += 8*nb;
        end
        blk[fill] = pad_word;
        fill++;
        if (fill > 14) begin
            while (fill < 16) blk[fill++] = '0;
            compress();
            fill = 0;
        end
        while (fill < 14) blk[fill++] = '0;
        blk[14] = bit_len[63:32];
        blk[15] = bit_len[31:0];
        compress();
        for (int k = 0; k < 8; k++)
            digest_q.push_back('{digest_word: chain[k], last_word: (k == 7)});
        restart_hash();
    endtask

    task automatic send_word(sm3_pkg::t_in_word cmd, logic known, logic [255:0] digest);
        while ($urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= cmd;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
        predict_digest(cmd);
        if (known) begin
            repeat (8) void'(digest_q.pop_back());
            for (int k = 0; k < 8; k++)
                digest_q.push_back('{digest_word: digest[255 - 32*k -: 32],
                                     last_word: (k == 7)});
        end
    endtask

    function automatic t_row mk(logic [31:0] w, logic [2:0] nb, logic fin,
                                logic known = 0, logic [255:0] dg = '0);
        t_row r;
        r.word = w; r.nbytes = nb; r.fin = fin; r.known = known; r.digest = dg;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, out_ch.data);
                    errors++;
                end else begin
                    if (out_ch.data !== digest_q[0])
                        $display("%0t: expected %h, got %h", $time, digest_q[0], out_ch.data);
                    if (out_ch.data !== digest_q[0]) errors++;
                    void'(digest_q.pop_front());
                    if (out_ch.data.last_word) digests++;
                end
            end
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        sm3_pkg::t_in_word cmd;
        int                len;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        i_rst_n     <= 1'b0;
        restart_hash();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back(mk(32'h0, 3'd0, 1, 1, {32'h1ab21d83, 32'h55cfa17f, 32'h8e611948,
            32'h31e81a8f, 32'h22bec8c7, 32'h28fefb74, 32'h7ed035eb, 32'h5082aa2b}));
        rows.push_back(mk(32'h616263ff, 3'd3, 1, 1, {32'h66c7f0f4, 32'h62eeedd9,
            32'hd1f2d46b, 32'hdc10e4e2, 32'h4167c487, 32'h5cf2f7a2, 32'h297da02b,
            32'h8f4ba8e0}));
        rows.push_back(mk(32'hffffffff, 3'd4, 1));
        rows.push_back(mk(32'h00000000, 3'd7, 1));
        rows.push_back(mk(32'h12345678, 3'd0, 0));
        rows.push_back(mk(32'hdeadbeef, 3'd5, 0));
        rows.push_back(mk(32'habffffff, 3'd1, 1));
        for (int k = 0; k < 13; k++) rows.push_back(mk(32'h5a5a0000 + k, 3'd4, 0));
        rows.push_back(mk(32'hffffffff, 3'd2, 1));
        rows.push_back(mk(32'hffffffff, 3'd6, 1));
        for (int k = 0; k < 15; k++) rows.push_back(mk(32'h3c3c0000 + k, 3'd4, 0));
        rows.push_back(mk(32'h89abcdef, 3'd4, 1));
        for (int k = 0; k < 14; k++) rows.push_back(mk(32'hc3c30000 + k, 3'd4, 0));
        rows.push_back(mk(32'h01234567, 3'd1, 1));
        foreach (rows[i]) begin
            cmd.message_word = rows[i].word;
            cmd.byte_count   = rows[i].nbytes;
            cmd.final_word   = rows[i].fin;
            send_word(cmd, rows[i].known, rows[i].digest);
        end

        while (words_sent < rows.size() + N_RANDOM) begin
            case (((words_sent - rows.size()) * 4) / N_RANDOM)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 66; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 66; end
                default: begin gap_pct = 35; stall_pct = 35; end
            endcase
            len = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(17, 12);
            for (int k = 0; k < len; k++) begin
                cmd.message_word = $urandom;
                cmd.byte_count   = 3'($urandom_range(7));
                cmd.final_word   = 1'b0;
                send_word(cmd, 0, '0);
            end
            cmd.message_word = $urandom;
            cmd.byte_count   = 3'($urandom_range(7));
            cmd.final_word   = 1'b1;
            send_word(cmd, 0, '0);
        end
        in_ch.valid <= 1'b0;

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d words and checked %0d digests under four idle patterns.",
                 words_sent, digests);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
